/* rtl/tsc_pkg.sv */
// Shared types and constants of the text screen cursor buffer.
// No dependencies; used by tsc_store, the top level and the testbench.
`default_nettype none

package tsc_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 128;

  localparam int ACT_W      = 4;
  localparam int REP_W      = 8;
  localparam int TROW_W     = 7;
  localparam int TCOL_W     = 8;
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 13;
  localparam int ROW_OUT_W  = 7;
  localparam int ROWS_REG_W = 7;
  localparam int COLS_REG_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0]     BLANK_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0]     NULL_CHAR  = 8'h00;
  localparam logic [ROWS_REG_W-1:0] RESET_ROWS = 7'd8;
  localparam logic [COLS_REG_W-1:0] RESET_COLS = 8'd40;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  typedef enum logic [ACT_W-1:0] {
    ACT_HOME    = 4'd0,
    ACT_FWD     = 4'd1,
    ACT_BACK    = 4'd2,
    ACT_UP      = 4'd3,
    ACT_DOWN    = 4'd4,
    ACT_END     = 4'd5,
    ACT_MOVE_TO = 4'd6,
    ACT_READ_AT = 4'd7,
    ACT_READ    = 4'd8,
    ACT_WRITE   = 4'd9
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BELL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_NULL  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CFG_AREA,
    S_CFG_CHECK,
    S_MOVE,
    S_ABS_MUL,
    S_ABS_ADD,
    S_WRITE,
    S_DIV_INIT,
    S_DIV,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

/* rtl/tsc_alu.sv */
// Shared add/subtract unit with carry-out and compare against a bound.
// Depends on nothing; instantiated by the top level sequencer.
`default_nettype none

module tsc_alu #(
  parameter int W = 14
) (
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic         sub_i,
  input  wire logic [W-1:0] bound_i,
  output logic      [W-1:0] res_o,
  output logic              carry_o,
  output logic              ge_bound_o
);

  logic [W:0] full;

  always_comb begin
    if (sub_i) begin
      full = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      full = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  assign res_o      = full[W-1:0];
  assign carry_o    = full[W];
  assign ge_bound_o = (full >= {1'b0, bound_i});

endmodule

`default_nettype wire

/* rtl/tsc_store.sv */
// Character cell memory with a clearing sweep after reset.
// Depends on tsc_pkg for the blank character.
`default_nettype none

module tsc_store #(
  parameter int CELLS = 8192,
  parameter int AW    = 13
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [tsc_pkg::CHAR_W-1:0] wdata_i,
  input  wire logic [AW-1:0]             raddr_i,
  output logic      [tsc_pkg::CHAR_W-1:0] rdata_o,
  output logic                           busy_o
);

  logic [tsc_pkg::CHAR_W-1:0] mem [CELLS];
  logic [AW-1:0]              clr_q;
  logic                       busy_q;
  logic                       wr;
  logic [AW-1:0]              wa;
  logic [tsc_pkg::CHAR_W-1:0] wd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (clr_q == AW'(CELLS - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_comb begin
    if (busy_q) begin
      wr = 1'b1;
      wa = clr_q;
      wd = tsc_pkg::BLANK_CHAR;
    end else begin
      wr = we_i;
      wa = waddr_i;
      wd = wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

/* rtl/text_screen_cursor_buffer_unit.sv */
// Text screen cursor buffer: top level with the command sequencer.
// Depends on tsc_pkg, tsc_alu and tsc_store.
//
// Usage:
//   Commands arrive on the input channel (valid/stall), one result beat per
//   command leaves on the output channel (valid/stall). rows_used and
//   cols_used are written on the cfg channel (valid/ready) while idle.
//   One command is worked on at a time; in_stall_o is high meanwhile.
//   From accept to the result register: a movement steps the cursor once per
//     repeat, an absolute move multiplies and then adds (only the range check
//     if out of range), a write stores the character, a read or unused action
//     does nothing; then the row is found by division on the shared adder and
//     the output register is loaded; the next command is taken after that load.
//   A finished result sits in the output register while the next command
//   is accepted; a new result waits in the sequencer while out_stall_i
//   holds the previous one.
//   After reset the cell memory is swept to '*', one cell per cycle; no command
//   is taken until the sweep ends and the cursor is checked against the area.
//   Config writes are accepted during the sweep.
//   A config write rechecks the cursor against the area in S_CFG_AREA and S_CFG_CHECK.
`default_nettype none

module text_screen_cursor_buffer_unit #(
  parameter int MAX_ROWS = tsc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = tsc_pkg::DEF_MAX_COLS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [tsc_pkg::ACT_W-1:0]        action_i,
  input  wire logic [tsc_pkg::REP_W-1:0]        repeat_count_i,
  input  wire logic [tsc_pkg::TROW_W-1:0]       target_row_i,
  input  wire logic [tsc_pkg::TCOL_W-1:0]       target_col_i,
  input  wire logic [tsc_pkg::CHAR_W-1:0]       char_in_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [tsc_pkg::CHAR_W-1:0]       char_out_o,
  output logic      [tsc_pkg::POS_W-1:0]        cursor_pos_o,
  output logic      [tsc_pkg::ROW_OUT_W-1:0]    cursor_row_o,
  output logic      [1:0]                       status_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tsc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [tsc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DW    = CW + 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNW   = (RW > 1) ? $clog2(RW) : 1;
  localparam int RRW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int PW    = (CW > tsc_pkg::POS_W) ? CW : tsc_pkg::POS_W;
  localparam int OW    = (RW + 1 > tsc_pkg::ROW_OUT_W) ? RW + 1 : tsc_pkg::ROW_OUT_W;

  tsc_pkg::state_e state_q, state_d;

  logic [tsc_pkg::ROWS_REG_W-1:0] rows_q;
  logic [tsc_pkg::COLS_REG_W-1:0] cols_q;
  logic [RRW-1:0]                 eff_rows;
  logic [CCW-1:0]                 eff_cols;
  logic [RRW+CCW-1:0]             area_prod;
  logic [DW-1:0]                  area_q;
  logic [DW-1:0]                  cols_ext;

  logic [CW-1:0]                  cursor_q, cursor_d;
  tsc_pkg::act_e                  act_q, act_d;
  logic [tsc_pkg::REP_W-1:0]      rep_q, rep_d;
  logic [tsc_pkg::TROW_W-1:0]     tr_q, tr_d;
  logic [tsc_pkg::TCOL_W-1:0]     tc_q, tc_d;
  logic [tsc_pkg::CHAR_W-1:0]     ch_q, ch_d;
  tsc_pkg::status_e               status_q, status_d;
  logic [DW-1:0]                  prod_q, prod_d;
  logic [DW-1:0]                  rem_q, rem_d;
  logic [RW-1:0]                  quot_q, quot_d;
  logic [CNW-1:0]                 cnt_q, cnt_d;
  logic [tsc_pkg::TROW_W+CCW-1:0] abs_prod;
  logic                           abs_bad;

  logic                           out_valid_q, out_valid_d;
  logic                           out_load;
  logic [tsc_pkg::CHAR_W-1:0]     char_out_q;
  logic [tsc_pkg::POS_W-1:0]      pos_out_q;
  logic [tsc_pkg::ROW_OUT_W-1:0]  row_out_q;
  tsc_pkg::status_e               st_out_q;
  logic [PW-1:0]                  pos_ext;
  logic [OW-1:0]                  row_ext;

  logic [DW-1:0]                  alu_a, alu_b, alu_res;
  logic                           alu_sub, alu_carry, alu_ge;

  logic                           mem_we;
  logic [tsc_pkg::CHAR_W-1:0]     mem_rdata;
  logic                           store_busy;

  logic                           cfg_we;
  logic                           in_fire;

  assign cfg_ready_o = (state_q == tsc_pkg::S_IDLE) || (state_q == tsc_pkg::S_CLEAR);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != tsc_pkg::S_IDLE) || cfg_valid_i;
  assign in_fire     = in_valid_i && !in_stall_o;

  always_comb begin
    if (rows_q == '0) begin
      eff_rows = RRW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      eff_rows = RRW'(MAX_ROWS);
    end else begin
      eff_rows = RRW'(rows_q);
    end
    if (cols_q == '0) begin
      eff_cols = CCW'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      eff_cols = CCW'(MAX_COLS);
    end else begin
      eff_cols = CCW'(cols_q);
    end
  end

  assign area_prod = eff_rows * eff_cols;
  assign cols_ext  = DW'(eff_cols);
  assign abs_prod  = (tr_q - tsc_pkg::TROW_W'(1)) * eff_cols;
  assign abs_bad   = (tr_q == '0) || (32'(tr_q) > 32'(eff_rows)) ||
                     (tc_q == '0) || (32'(tc_q) > 32'(eff_cols));

  always_ff @(posedge clk_i) begin
    area_q <= DW'(area_prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= tsc_pkg::RESET_ROWS;
      cols_q <= tsc_pkg::RESET_COLS;
    end else if (cfg_we) begin
      case (cfg_index_i)
        tsc_pkg::CFG_ROWS: rows_q <= cfg_data_i[tsc_pkg::ROWS_REG_W-1:0];
        tsc_pkg::CFG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tsc_alu #(
    .W (DW)
  ) u_alu (
    .a_i        (alu_a),
    .b_i        (alu_b),
    .sub_i      (alu_sub),
    .bound_i    (area_q),
    .res_o      (alu_res),
    .carry_o    (alu_carry),
    .ge_bound_o (alu_ge)
  );

  tsc_store #(
    .CELLS (CELLS),
    .AW    (CW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (cursor_q),
    .wdata_i (ch_q),
    .raddr_i (cursor_q),
    .rdata_o (mem_rdata),
    .busy_o  (store_busy)
  );

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    act_d       = act_q;
    rep_d       = rep_q;
    tr_d        = tr_q;
    tc_d        = tc_q;
    ch_d        = ch_q;
    status_d    = status_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    alu_a       = DW'(cursor_q);
    alu_b       = '0;
    alu_sub     = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      tsc_pkg::S_CLEAR: begin
        if (!store_busy) begin
          state_d = tsc_pkg::S_CFG_AREA;
        end
      end
      tsc_pkg::S_IDLE: begin
        if (cfg_we) begin
          state_d = tsc_pkg::S_CFG_AREA;
        end else if (in_fire) begin
          act_d    = tsc_pkg::act_e'(action_i);
          rep_d    = repeat_count_i;
          tr_d     = target_row_i;
          tc_d     = target_col_i;
          ch_d     = char_in_i;
          status_d = tsc_pkg::ST_OK;
          case (tsc_pkg::act_e'(action_i))
            tsc_pkg::ACT_HOME, tsc_pkg::ACT_FWD, tsc_pkg::ACT_BACK,
            tsc_pkg::ACT_UP, tsc_pkg::ACT_DOWN, tsc_pkg::ACT_END:
              state_d = tsc_pkg::S_MOVE;
            tsc_pkg::ACT_MOVE_TO, tsc_pkg::ACT_READ_AT:
              state_d = tsc_pkg::S_ABS_MUL;
            tsc_pkg::ACT_WRITE:
              state_d = tsc_pkg::S_WRITE;
            default:
              state_d = tsc_pkg::S_DIV_INIT;
          endcase
        end
      end
      tsc_pkg::S_CFG_AREA: begin
        state_d = tsc_pkg::S_CFG_CHECK;
      end
      tsc_pkg::S_CFG_CHECK: begin
        alu_b   = area_q;
        alu_sub = 1'b1;
        if (!alu_carry) begin
          cursor_d = '0;
        end
        state_d = tsc_pkg::S_IDLE;
      end
      tsc_pkg::S_MOVE: begin
        if (rep_q == '0) begin
          state_d = tsc_pkg::S_DIV_INIT;
        end else begin
          rep_d = rep_q - tsc_pkg::REP_W'(1);
          case (act_q)
            tsc_pkg::ACT_HOME: begin
              cursor_d = '0;
            end
            tsc_pkg::ACT_FWD: begin
              alu_b    = DW'(1);
              cursor_d = alu_ge ? '0 : alu_res[CW-1:0];
            end
            tsc_pkg::ACT_BACK: begin
              if (cursor_q == '0) begin
                alu_a = area_q;
              end
              alu_b    = DW'(1);
              alu_sub  = 1'b1;
              cursor_d = alu_res[CW-1:0];
            end
            tsc_pkg::ACT_UP: begin
              alu_b   = cols_ext;
              alu_sub = 1'b1;
              if (alu_carry) begin
                status_d = tsc_pkg::ST_BELL;
              end else begin
                cursor_d = alu_res[CW-1:0];
              end
            end
            tsc_pkg::ACT_DOWN: begin
              alu_b = cols_ext;
              if (alu_ge) begin
                status_d = tsc_pkg::ST_BELL;
              end else begin
                cursor_d = alu_res[CW-1:0];
              end
            end
            default: begin
              alu_a    = area_q;
              alu_b    = DW'(1);
              alu_sub  = 1'b1;
              cursor_d = alu_res[CW-1:0];
            end
          endcase
        end
      end
      tsc_pkg::S_ABS_MUL: begin
        if (abs_bad) begin
          status_d = tsc_pkg::ST_RANGE;
          state_d  = tsc_pkg::S_DIV_INIT;
        end else begin
          prod_d  = DW'(abs_prod);
          state_d = tsc_pkg::S_ABS_ADD;
        end
      end
      tsc_pkg::S_ABS_ADD: begin
        alu_a    = prod_q;
        alu_b    = DW'(tc_q - tsc_pkg::TCOL_W'(1));
        cursor_d = alu_res[CW-1:0];
        state_d  = tsc_pkg::S_DIV_INIT;
      end
      tsc_pkg::S_WRITE: begin
        if (ch_q == tsc_pkg::NULL_CHAR) begin
          status_d = tsc_pkg::ST_NULL;
        end else begin
          mem_we = 1'b1;
        end
        state_d = tsc_pkg::S_DIV_INIT;
      end
      tsc_pkg::S_DIV_INIT: begin
        rem_d   = DW'(cursor_q);
        quot_d  = '0;
        cnt_d   = CNW'(RW - 1);
        state_d = tsc_pkg::S_DIV;
      end
      tsc_pkg::S_DIV: begin
        alu_a   = rem_q;
        alu_b   = cols_ext << cnt_q;
        alu_sub = 1'b1;
        if (!alu_carry) begin
          rem_d  = alu_res;
          quot_d = quot_q | (RW'(1) << cnt_q);
        end
        if (cnt_q == '0) begin
          state_d = tsc_pkg::S_OUT;
        end else begin
          cnt_d = cnt_q - CNW'(1);
        end
      end
      tsc_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = tsc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tsc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsc_pkg::S_CLEAR;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    rep_q    <= rep_d;
    tr_q     <= tr_d;
    tc_q     <= tc_d;
    ch_q     <= ch_d;
    status_q <= status_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    quot_q   <= quot_d;
    cnt_q    <= cnt_d;
  end

  assign pos_ext = PW'(cursor_q);
  assign row_ext = OW'(quot_q) + OW'(1);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      char_out_q <= mem_rdata;
      pos_out_q  <= pos_ext[tsc_pkg::POS_W-1:0];
      row_out_q  <= row_ext[tsc_pkg::ROW_OUT_W-1:0];
      st_out_q   <= status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_out_o   = char_out_q;
  assign cursor_pos_o = pos_out_q;
  assign cursor_row_o = row_out_q;
  assign status_o     = st_out_q;

`ifndef SYNTHESIS
  a_cursor_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsc_pkg::S_IDLE) |-> (DW'(cursor_q) < area_q))
    else $error("cursor outside screen area while idle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("command accepted while previous one still in work");

  a_bell_only_vertical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsc_pkg::S_OUT && status_q == tsc_pkg::ST_BELL) |->
    (act_q == tsc_pkg::ACT_UP || act_q == tsc_pkg::ACT_DOWN))
    else $error("bell status from a non-vertical action");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsc_pkg::S_OUT) |-> (32'(quot_q) < 32'(eff_rows)))
    else $error("row quotient beyond rows in use");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_text_screen_cursor_buffer_unit.sv */
`timescale 1ns / 1ps
// Testbench for text_screen_cursor_buffer_unit: a directed table of cursor commands, then
// random phases across screen sizes, checked against typed views or a behavioral predictor.
// Depends on tsc_pkg and the RTL of the block.

module tb_text_screen_cursor_buffer_unit;
  import tsc_pkg::*;

  localparam int MAX_ROWS       = DEF_MAX_ROWS;
  localparam int MAX_COLS       = DEF_MAX_COLS;
  localparam int STORE_CELLS    = MAX_ROWS * MAX_COLS;
  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 12;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 92;
  localparam int LONG_HOLD      = 600;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [ACT_W-1:0]     ACT_UNUSED_LO = 4'd10;
  localparam logic [ACT_W-1:0]     ACT_UNUSED_HI = 4'd15;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B   = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [REP_W-1:0]  repeat_count;
    logic [TROW_W-1:0] target_row;
    logic [TCOL_W-1:0] target_col;
    logic [CHAR_W-1:0] char_in;
  } cursor_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0]    ch;
    logic [POS_W-1:0]     pos;
    logic [ROW_OUT_W-1:0] row;
    status_e              st;
  } cell_view_t;

  typedef struct {
    cursor_cmd_t cmd;
    bit          typed;
    cell_view_t  view;
  } probe_row_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [ACT_W-1:0]      action_i       = '0;
  logic [REP_W-1:0]      repeat_count_i = '0;
  logic [TROW_W-1:0]     target_row_i   = '0;
  logic [TCOL_W-1:0]     target_col_i   = '0;
  logic [CHAR_W-1:0]     char_in_i      = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [CHAR_W-1:0]     char_out_o;
  logic [POS_W-1:0]      cursor_pos_o;
  logic [ROW_OUT_W-1:0]  cursor_row_o;
  logic [1:0]            status_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  text_screen_cursor_buffer_unit #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .repeat_count_i(repeat_count_i),
    .target_row_i  (target_row_i),
    .target_col_i  (target_col_i),
    .char_in_i     (char_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_out_o    (char_out_o),
    .cursor_pos_o  (cursor_pos_o),
    .cursor_row_o  (cursor_row_o),
    .status_o      (status_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor state
  logic [CHAR_W-1:0]     shadow_cells [STORE_CELLS];
  int unsigned           shadow_cursor;
  logic [ROWS_REG_W-1:0] shadow_rows;
  logic [COLS_REG_W-1:0] shadow_cols;

  cell_view_t expected_views [$];
  int         mismatches   = 0;
  int         results_seen = 0;
  int         stuck_cycles = 0;
  bit         hold_request = 1'b0;
  bit         quiet_end    = 1'b0;

  // Default screen is 8 x 40: last cell 319 on row 8.
  probe_row_t directed_rows [26] = '{
    '{'{ACT_READ,    8'd0,   7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd0,   7'd1, ST_OK}},
    '{'{ACT_UP,      8'd1,   7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd0,   7'd1, ST_BELL}},
    '{'{ACT_BACK,    8'd1,   7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd319, 7'd8, ST_OK}},
    '{'{ACT_FWD,     8'd1,   7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd0,   7'd1, ST_OK}},
    '{'{ACT_END,     8'd1,   7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd319, 7'd8, ST_OK}},
    '{'{ACT_DOWN,    8'd1,   7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd319, 7'd8, ST_BELL}},
    '{'{ACT_HOME,    8'd0,   7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd319, 7'd8, ST_OK}},
    '{'{ACT_HOME,    8'd255, 7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd0,   7'd1, ST_OK}},
    '{'{ACT_WRITE,   8'd0,   7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd0,   7'd1, ST_NULL}},
    '{'{ACT_WRITE,   8'd0,   7'd0,   8'd0,   8'hFF}, 1'b1, '{8'hFF,      13'd0,   7'd1, ST_OK}},
    '{'{ACT_MOVE_TO, 8'd0,   7'd0,   8'd1,   8'h00}, 1'b1, '{8'hFF,      13'd0,   7'd1, ST_RANGE}},
    '{'{ACT_MOVE_TO, 8'd0,   7'd9,   8'd1,   8'h00}, 1'b1, '{8'hFF,      13'd0,   7'd1, ST_RANGE}},
    '{'{ACT_MOVE_TO, 8'd0,   7'd1,   8'd41,  8'h00}, 1'b1, '{8'hFF,      13'd0,   7'd1, ST_RANGE}},
    '{'{ACT_MOVE_TO, 8'd255, 7'd127, 8'd255, 8'hFF}, 1'b1, '{8'hFF,      13'd0,   7'd1, ST_RANGE}},
    '{'{ACT_READ_AT, 8'd0,   7'd8,   8'd40,  8'h00}, 1'b1, '{BLANK_CHAR, 13'd319, 7'd8, ST_OK}},
    '{'{ACT_WRITE,   8'd0,   7'd0,   8'd0,   8'h80}, 1'b1, '{8'h80,      13'd319, 7'd8, ST_OK}},
    '{'{ACT_READ_AT, 8'd0,   7'd1,   8'd0,   8'h00}, 1'b1, '{8'h80,      13'd319, 7'd8, ST_RANGE}},
    '{'{ACT_MOVE_TO, 8'd0,   7'd1,   8'd1,   8'h00}, 1'b1, '{8'hFF,      13'd0,   7'd1, ST_OK}},
    '{'{ACT_DOWN,    8'd7,   7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd280, 7'd8, ST_OK}},
    '{'{ACT_DOWN,    8'd255, 7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd280, 7'd8, ST_BELL}},
    '{'{ACT_UP,      8'd3,   7'd0,   8'd0,   8'h00}, 1'b1, '{BLANK_CHAR, 13'd160, 7'd5, ST_OK}},
    '{'{ACT_UP,      8'd255, 7'd5,   8'd3,   8'h41}, 1'b0, '0},
    '{'{ACT_FWD,     8'd255, 7'd0,   8'd0,   8'h00}, 1'b0, '0},
    '{'{ACT_BACK,    8'd255, 7'd0,   8'd0,   8'h00}, 1'b0, '0},
    '{'{ACT_UNUSED_LO, 8'd4, 7'd2,   8'd2,   8'h33}, 1'b0, '0},
    '{'{ACT_UNUSED_HI, 8'hFF, 7'h7F, 8'hFF,  8'hFF}, 1'b0, '0}
  };

  logic [CFG_DATA_W-1:0] phase_rows [PHASES] = '{8'd1, 8'd64, 8'd0, 8'h85, 8'hFF, 8'd64, 8'd1, 8'd8};
  logic [CFG_DATA_W-1:0] phase_cols [PHASES] = '{8'd1, 8'd128, 8'hFF, 8'd0, 8'd3, 8'd1, 8'd128, 8'd40};

  function automatic int unsigned rows_eff();
    int unsigned r;
    r = shadow_rows;
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  function automatic int unsigned cols_eff();
    int unsigned c;
    c = shadow_cols;
    if (c < 1) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  function automatic void set_screen_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_ROWS || idx == CFG_COLS) begin
      if (idx == CFG_ROWS) shadow_rows = val[ROWS_REG_W-1:0];
      else shadow_cols = val[COLS_REG_W-1:0];
      if (shadow_cursor >= rows_eff() * cols_eff()) shadow_cursor = 0;
    end
  endfunction

  function automatic cell_view_t apply_cursor_cmd(cursor_cmd_t c);
    int unsigned rows;
    int unsigned cols;
    int unsigned area;
    int unsigned row;
    status_e     st;
    cell_view_t  v;
    rows = rows_eff();
    cols = cols_eff();
    area = rows * cols;
    st = ST_OK;
    if (shadow_cursor >= area) shadow_cursor = 0;
    if (c.action <= ACT_END) begin
      for (int i = 0; i < int'(c.repeat_count); i++) begin
        row = shadow_cursor / cols + 1;
        case (c.action)
          ACT_HOME: shadow_cursor = 0;
          ACT_FWD:  shadow_cursor = (shadow_cursor + 1 >= area) ? 0 : shadow_cursor + 1;
          ACT_BACK: shadow_cursor = (shadow_cursor == 0) ? area - 1 : shadow_cursor - 1;
          ACT_UP: begin
            if (row == 1) st = ST_BELL;
            else shadow_cursor -= cols;
          end
          ACT_DOWN: begin
            if (row >= rows) st = ST_BELL;
            else shadow_cursor += cols;
          end
          default: shadow_cursor = area - 1;
        endcase
      end
    end else if (c.action == ACT_MOVE_TO || c.action == ACT_READ_AT) begin
      if (c.target_row < 1 || int'(c.target_row) > rows || c.target_col < 1 ||
          int'(c.target_col) > cols) begin
        st = ST_RANGE;
      end else begin
        shadow_cursor = (int'(c.target_row) - 1) * cols + (int'(c.target_col) - 1);
      end
    end else if (c.action == ACT_WRITE) begin
      if (c.char_in == NULL_CHAR) st = ST_NULL;
      else shadow_cells[shadow_cursor % STORE_CELLS] = c.char_in;
    end
    v.ch  = shadow_cells[shadow_cursor % STORE_CELLS];
    v.pos = shadow_cursor[POS_W-1:0];
    v.row = ROW_OUT_W'(shadow_cursor / cols + 1);
    v.st  = st;
    return v;
  endfunction

  function automatic cursor_cmd_t rand_cursor_cmd();
    cursor_cmd_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) c.repeat_count = REP_W'($urandom_range(0, 255));
    else c.repeat_count = REP_W'($urandom_range(0, 6));
    c.target_row = TROW_W'($urandom_range(1, rows_eff()));
    c.target_col = TCOL_W'($urandom_range(1, cols_eff()));
    if ($urandom_range(0, 7) == 0) begin
      c.target_row = TROW_W'($urandom);
      c.target_col = TCOL_W'($urandom);
    end
    if ($urandom_range(0, 15) == 0) c.char_in = NULL_CHAR;
    else c.char_in = CHAR_W'($urandom_range(1, 255));
    if (pick < 50) c.action = ACT_W'($urandom_range(int'(ACT_HOME), int'(ACT_END)));
    else if (pick < 62) c.action = ACT_MOVE_TO;
    else if (pick < 72) c.action = ACT_READ_AT;
    else if (pick < 78) c.action = ACT_READ;
    else if (pick < 96) c.action = ACT_WRITE;
    else c.action = ACT_W'($urandom_range(int'(ACT_UNUSED_LO), int'(ACT_UNUSED_HI)));
    return c;
  endfunction

  task automatic send_cmd(input cursor_cmd_t c, input bit typed, input cell_view_t typed_view);
    cell_view_t predicted;
    in_valid_i     <= 1'b1;
    action_i       <= c.action;
    repeat_count_i <= c.repeat_count;
    target_row_i   <= c.target_row;
    target_col_i   <= c.target_col;
    char_in_i      <= c.char_in;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_cursor_cmd(c);
    expected_views.push_back(typed ? typed_view : predicted);
    if (!quiet_end && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_results_drained();
    while (expected_views.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_screen_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    set_screen_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch on %s in beat %0d: expected 0x%0h, got 0x%0h",
                 what, results_seen, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    cell_view_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result beat: char 0x%0h pos %0d row %0d status %0d",
                   char_out_o, cursor_pos_o, cursor_row_o, status_o);
      end else begin
        want = expected_views.pop_front();
        check_field("char_out", want.ch, char_out_o);
        check_field("cursor_pos", want.pos, cursor_pos_o);
        check_field("cursor_row", want.row, cursor_row_o);
        check_field("status", want.st, status_o);
      end
      results_seen++;
    end
  end

  // Receiver: random stall bursts, one long hold on request, none at the end
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_request = 1'b0;
      end else if (!quiet_end && $urandom_range(0, 11) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORE_CELLS; i++) shadow_cells[i] = BLANK_CHAR;
    shadow_cursor = 0;
    shadow_rows   = RESET_ROWS;
    shadow_cols   = RESET_COLS;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].view);
    drop_valid();

    for (int p = 0; p < PHASES; p++) begin
      wait_results_drained();
      if (p == PHASES - 1) begin
        quiet_end = 1'b1;
        phase_rows[p] = CFG_DATA_W'($urandom_range(1, MAX_ROWS));
        phase_cols[p] = CFG_DATA_W'($urandom_range(1, MAX_COLS));
      end
      write_screen_reg(CFG_ROWS, phase_rows[p]);
      write_screen_reg(CFG_COLS, phase_cols[p]);
      if (p == 2) begin
        write_screen_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        write_screen_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
      end
      if (p == 1) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) begin
          drop_valid();
          wait_results_drained();
        end
        send_cmd(rand_cursor_cmd(), 1'b0, '0);
      end
      drop_valid();
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* text_screen_cursor_buffer_unit.f */
rtl/tsc_pkg.sv
rtl/tsc_alu.sv
rtl/tsc_store.sv
rtl/text_screen_cursor_buffer_unit.sv
tb/sv/tb_text_screen_cursor_buffer_unit.sv
